/* rtl/assert_macros.svh */
// Assertion macros used by the top level of the schema checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

/* rtl/ptsc_pkg.sv */
// Shared constants, types and control structs of the schema checker.
`default_nettype none

package ptsc_pkg;

  localparam int DEF_MAX_DEPTH    = 10;
  localparam int DEF_MAX_ELEMENTS = 65536;

  localparam int DEPTH_W  = 4;
  localparam int COUNT_W  = 16;
  localparam int STATUS_W = 2;

  localparam logic OP_ELEMENT = 1'b0;
  localparam logic OP_END     = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_LIMITS  = 2'd2
  } status_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;  // capture the accepted item
    logic eval;  // checks, result fields, push of the element
    logic pop;   // one step of the walk back up the level stack
    logic emit;  // move the result into the output register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic go_pop;    // element passed its checks, level walk follows
    logic pop_stop;  // walk has reached an open level or the root
  } sts_t;

endpackage

`default_nettype wire

/* rtl/ptsc_elem_if.sv */
// Input channel: one schema element or the end item.
`default_nettype none

interface ptsc_elem_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [ptsc_pkg::COUNT_W-1:0] child_count;

  modport source (output valid, output operation, output child_count, input ready);
  modport sink   (input valid, input operation, input child_count, output ready);
endinterface

`default_nettype wire

/* rtl/ptsc_result_if.sv */
// Output channel: placement and status of one item.
`default_nettype none

interface ptsc_result_if;
  logic                          valid;
  logic                          ready;
  logic [ptsc_pkg::DEPTH_W-1:0]  depth;
  logic                          has_parent;
  logic [ptsc_pkg::COUNT_W-1:0]  parent_index;
  logic [ptsc_pkg::COUNT_W-1:0]  child_position;
  logic [ptsc_pkg::STATUS_W-1:0] status;

  modport source (output valid, output depth, output has_parent, output parent_index,
                  output child_position, output status, input ready);
  modport sink   (input valid, input depth, input has_parent, input parent_index,
                  input child_position, input status, output ready);
endinterface

`default_nettype wire

/* rtl/ptsc_datapath.sv */
// Level stack, counters, error latch and result registers of the schema checker.
`default_nettype none

module ptsc_datapath #(
  parameter int MAX_DEPTH    = ptsc_pkg::DEF_MAX_DEPTH,
  parameter int MAX_ELEMENTS = ptsc_pkg::DEF_MAX_ELEMENTS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ptsc_pkg::cmd_t                cmd,
  output ptsc_pkg::sts_t                sts,
  input  logic                          operation,
  input  logic [ptsc_pkg::COUNT_W-1:0]  child_count,
  output logic [ptsc_pkg::DEPTH_W-1:0]  depth,
  output logic                          has_parent,
  output logic [ptsc_pkg::COUNT_W-1:0]  parent_index,
  output logic [ptsc_pkg::COUNT_W-1:0]  child_position,
  output ptsc_pkg::status_t             status
);

  localparam int LVL_W = $clog2(MAX_DEPTH);
  localparam int NXT_W = $clog2(MAX_DEPTH + 1);
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam logic [NXT_W-1:0] DEPTH_LIMIT = NXT_W'(MAX_DEPTH);
  localparam logic [CNT_W-1:0] ELEM_LIMIT  = CNT_W'(MAX_ELEMENTS);

  // item capture
  logic                         op_r;
  logic [ptsc_pkg::COUNT_W-1:0] kids_r;

  // level stack
  logic [ptsc_pkg::COUNT_W-1:0] remaining [MAX_DEPTH];
  logic [ptsc_pkg::COUNT_W-1:0] total     [MAX_DEPTH];
  logic [ptsc_pkg::COUNT_W-1:0] parent    [MAX_DEPTH];

  logic                         root_seen;
  logic [LVL_W-1:0]             cur_level;
  logic [LVL_W-1:0]             walk_lvl;
  logic [CNT_W-1:0]             counter;
  logic [ptsc_pkg::COUNT_W-1:0] pend_parent;
  logic [ptsc_pkg::COUNT_W-1:0] pend_pos;
  logic                         pend_valid;
  ptsc_pkg::status_t            error_code;

  // staged result
  logic [ptsc_pkg::DEPTH_W-1:0] res_depth;
  logic                         res_hp;
  logic [ptsc_pkg::COUNT_W-1:0] res_pi;
  logic [ptsc_pkg::COUNT_W-1:0] res_cp;
  ptsc_pkg::status_t            res_status;

  logic [ptsc_pkg::COUNT_W-1:0] rem_cur;
  logic                         take;
  logic                         pop_stop;
  logic [NXT_W-1:0]             lvl_after;
  logic                         too_deep;
  ptsc_pkg::status_t            check_code;
  ptsc_pkg::status_t            end_code;

  always_comb begin
    rem_cur   = remaining[walk_lvl];
    take      = (rem_cur != '0);
    pop_stop  = (walk_lvl == '0) || take;
    lvl_after = NXT_W'(walk_lvl) + NXT_W'(take);
    too_deep  = (lvl_after >= DEPTH_LIMIT);

    if (counter >= ELEM_LIMIT) begin
      check_code = ptsc_pkg::ST_LIMITS;
    end else if ((counter == '0 && kids_r == '0) || (cur_level == '0 && root_seen)) begin
      check_code = ptsc_pkg::ST_INVALID;
    end else begin
      check_code = ptsc_pkg::ST_OK;
    end

    if (error_code != ptsc_pkg::ST_OK) begin
      end_code = error_code;
    end else if (counter == '0 || cur_level != '0) begin
      end_code = ptsc_pkg::ST_INVALID;  // empty list or tree left open
    end else begin
      end_code = ptsc_pkg::ST_OK;
    end

    sts.go_pop   = (op_r == ptsc_pkg::OP_ELEMENT) && (error_code == ptsc_pkg::ST_OK) &&
                   (check_code == ptsc_pkg::ST_OK);
    sts.pop_stop = pop_stop;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      remaining  <= '{default: '0};
      root_seen  <= 1'b0;
      cur_level  <= '0;
      walk_lvl   <= '0;
      counter    <= '0;
      pend_valid <= 1'b0;
      error_code <= ptsc_pkg::ST_OK;
    end else if (cmd.eval) begin
      if (op_r == ptsc_pkg::OP_END) begin
        remaining  <= '{default: '0};
        root_seen  <= 1'b0;
        cur_level  <= '0;
        walk_lvl   <= '0;
        counter    <= '0;
        pend_valid <= 1'b0;
        error_code <= ptsc_pkg::ST_OK;
      end else if (error_code == ptsc_pkg::ST_OK) begin
        if (check_code != ptsc_pkg::ST_OK) begin
          error_code <= check_code;
        end else begin
          remaining[cur_level] <= kids_r;
          root_seen            <= 1'b1;
          counter              <= counter + 1'b1;
          walk_lvl             <= cur_level;
        end
      end
    end else if (cmd.pop) begin
      if (!pop_stop) begin
        walk_lvl <= walk_lvl - 1'b1;  // level exhausted, climb one
      end else begin
        pend_valid <= take;
        if (take) begin
          remaining[walk_lvl] <= rem_cur - 1'b1;
        end
        if (too_deep) begin
          error_code <= ptsc_pkg::ST_LIMITS;
        end else begin
          cur_level <= lvl_after[LVL_W-1:0];
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= operation;
      kids_r <= child_count;
    end

    if (cmd.eval) begin
      res_depth  <= '0;
      res_hp     <= 1'b0;
      res_pi     <= '0;
      res_cp     <= '0;
      if (op_r == ptsc_pkg::OP_END) begin
        res_status <= end_code;
      end else if (error_code != ptsc_pkg::ST_OK) begin
        res_status <= error_code;
      end else if (check_code != ptsc_pkg::ST_OK) begin
        res_status <= check_code;
      end else begin
        res_depth  <= ptsc_pkg::DEPTH_W'(cur_level);
        res_hp     <= pend_valid;
        res_pi     <= pend_valid ? pend_parent : '0;
        res_cp     <= pend_valid ? pend_pos : '0;
        res_status <= ptsc_pkg::ST_OK;
        if (kids_r != '0) begin
          total[cur_level]  <= kids_r;
          parent[cur_level] <= ptsc_pkg::COUNT_W'(counter);
        end
      end
    end

    if (cmd.pop && pop_stop) begin
      pend_parent <= take ? parent[walk_lvl] : '0;
      pend_pos    <= take ? (total[walk_lvl] - rem_cur) : '0;
      if (too_deep) begin
        res_depth  <= '0;
        res_hp     <= 1'b0;
        res_pi     <= '0;
        res_cp     <= '0;
        res_status <= ptsc_pkg::ST_LIMITS;
      end
    end

    if (cmd.emit) begin
      depth          <= res_depth;
      has_parent     <= res_hp;
      parent_index   <= res_pi;
      child_position <= res_cp;
      status         <= res_status;
    end
  end

endmodule

`default_nettype wire

/* rtl/ptsc_ctrl.sv */
// Sequencing state machine and output valid flag of the schema checker.
`default_nettype none

module ptsc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  ptsc_pkg::sts_t sts,
  output ptsc_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_POP  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  always_comb begin
    out_free   = !out_valid || out_ready;
    in_ready   = (state == S_IDLE);
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = sts.go_pop ? S_POP : S_EMIT;
      end
      S_POP: begin
        cmd.pop = 1'b1;
        if (sts.pop_stop) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        // hold until the output register is free or draining
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/preorder_tree_schema_checker.sv */
// Top level of the preorder schema tree checker.
//
//   channel   | dir | payload                                               | handshake
//   ----------+-----+-------------------------------------------------------+-----------
//   elements  | in  | operation, child_count                                | valid/ready
//   results   | out | depth, has_parent, parent_index, child_position, status | valid/ready
//
// One item at a time: accept, evaluate, a walk back up the level stack one level
// per step, then the move into the output register; the walk covers 0 levels for
// the end item or a failing element, else 1 to MAX_DEPTH levels.
// The output register lets the next item be accepted while a result waits; the
// item after that stalls, and the input with it, until the register drains.
// Synchronous reset clears the level stack, counters and error latch at once.
`default_nettype none
`include "assert_macros.svh"

module preorder_tree_schema_checker #(
  parameter int MAX_DEPTH    = ptsc_pkg::DEF_MAX_DEPTH,
  parameter int MAX_ELEMENTS = ptsc_pkg::DEF_MAX_ELEMENTS
) (
  input  logic          clk,
  input  logic          rst,
  ptsc_elem_if.sink     elements,
  ptsc_result_if.source results
);

  ptsc_pkg::cmd_t    cmd;
  ptsc_pkg::sts_t    sts;
  ptsc_pkg::status_t dp_status;

  ptsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (elements.valid),
    .in_ready  (elements.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ptsc_datapath #(
    .MAX_DEPTH    (MAX_DEPTH),
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .operation      (elements.operation),
    .child_count    (elements.child_count),
    .depth          (results.depth),
    .has_parent     (results.has_parent),
    .parent_index   (results.parent_index),
    .child_position (results.child_position),
    .status         (dp_status)
  );

  assign results.status = dp_status;

  // a new item is never taken in the cycle after one was accepted
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, elements.valid && elements.ready, !elements.ready)
  // a waiting result is never overwritten
  `ASSERT_IMPLIES(a_no_overwrite, clk, rst, cmd.emit, !results.valid || results.ready)
  `ASSERT_NEXT(a_emit_shows, clk, rst, cmd.emit, results.valid)
  `ASSERT_IMPLIES(a_one_cmd, clk, rst, 1'b1, $onehot0({cmd.load, cmd.eval, cmd.pop, cmd.emit}))

endmodule

`default_nettype wire
